// ----- rtl/core/dgds_pkg.sv -----
// Package for the delay, gain and downmix-to-stereo block.
// Holds field widths, parameter defaults, request codes and register addresses; no dependencies.
package dgds_pkg;

  localparam int DEF_MAX_OPS      = 32;
  localparam int DEF_RING_FRAMES  = 4096;
  localparam int DEF_MAX_CHANNELS = 9;

  localparam int SAMPLE_W  = 24;
  localparam int GAIN_W    = 16;
  localparam int DELAY_W   = 12;
  localparam int CHAN_W    = 4;
  localparam int INDEX_W   = 5;
  localparam int ACC_W     = 32;
  localparam int CFG_OPS_W = 6;
  localparam int ROUND_SH  = 14;

  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_LOAD   = 1'b1;

  localparam logic REG_ACTIVE_OPS = 1'b0;

endpackage

// ----- rtl/core/delay_gain_downmix_to_stereo.sv -----
// Top level of the delay, gain and downmix-to-stereo block.
// Depends on dgds_pkg for widths, defaults and register addresses.
//
//  channel   signals                                     direction
//  item      item_valid, item_stall, op .. entry_gain    in
//  result    result_valid, result_stall, left_out ..     out
//  config    psel, penable, pwrite, paddr, pwdata ...    in/out
//
// After reset the block clears every word of the accumulator ring before it takes a request.
// A load request writes one table entry if its index is in range. A sample request for a
// channel in range walks the active entries; each entry whose source matches the channel
// reads, adds into and writes back one ring word. An end of frame then reads, emits and
// clears the current ring word.
// A held result stalls only the emit step; requests wait while item_stall is high.
module delay_gain_downmix_to_stereo #(
  parameter int MAX_OPS      = dgds_pkg::DEF_MAX_OPS,
  parameter int RING_FRAMES  = dgds_pkg::DEF_RING_FRAMES,
  parameter int MAX_CHANNELS = dgds_pkg::DEF_MAX_CHANNELS
) (
  input  logic                                  clk,
  input  logic                                  rst,

  input  logic                                  item_valid,
  output logic                                  item_stall,
  input  logic                                  op,
  input  logic [dgds_pkg::CHAN_W-1:0]           channel,
  input  logic signed [dgds_pkg::SAMPLE_W-1:0]  sample,
  input  logic                                  end_of_frame,
  input  logic [dgds_pkg::INDEX_W-1:0]          entry_index,
  input  logic [dgds_pkg::CHAN_W-1:0]           entry_source,
  input  logic                                  entry_dest,
  input  logic [dgds_pkg::DELAY_W-1:0]          entry_delay,
  input  logic [dgds_pkg::GAIN_W-1:0]           entry_gain,

  output logic                                  result_valid,
  input  logic                                  result_stall,
  output logic signed [dgds_pkg::SAMPLE_W-1:0]  left_out,
  output logic signed [dgds_pkg::SAMPLE_W-1:0]  right_out,
  output logic                                  clipped,

  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [dgds_pkg::APB_ADDR_W-1:0]       paddr,
  input  logic [dgds_pkg::APB_DATA_W-1:0]       pwdata,
  output logic [dgds_pkg::APB_DATA_W-1:0]       prdata,
  output logic                                  pready
);

  localparam int TW      = (MAX_OPS > 1) ? $clog2(MAX_OPS) : 1;
  localparam int NW      = $clog2(MAX_OPS + 1);
  localparam int RW      = $clog2(RING_FRAMES);
  localparam int SW      = dgds_pkg::SAMPLE_W;
  localparam int AW      = dgds_pkg::ACC_W;
  localparam int DW      = dgds_pkg::DELAY_W;
  localparam int PW      = SW + dgds_pkg::GAIN_W + 1;
  localparam int CW      = PW - dgds_pkg::ROUND_SH;
  localparam int RCP_SH  = DW + RW;
  localparam int RCP_PW  = 2 * DW + 2;
  localparam longint RCP_M = ((longint'(1) << RCP_SH) + longint'(RING_FRAMES) - longint'(1)) /
                             longint'(RING_FRAMES);

  typedef struct packed {
    logic [dgds_pkg::CHAN_W-1:0] src;
    logic                        dest;
    logic [RW-1:0]               delay;
    logic [dgds_pkg::GAIN_W-1:0] gain;
  } op_entry_t;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_LOAD, S_START, S_EVAL, S_ADD, S_FIN, S_EMIT
  } state_t;

  state_t state;

  logic [dgds_pkg::CFG_OPS_W-1:0] active_ops;

  op_entry_t op_table [MAX_OPS];
  op_entry_t tab_q;
  logic signed [AW-1:0] ring_l [RING_FRAMES];
  logic signed [AW-1:0] ring_r [RING_FRAMES];
  logic signed [AW-1:0] ring_l_q;
  logic signed [AW-1:0] ring_r_q;

  logic [RW-1:0]                 fp;
  logic [RW-1:0]                 clr_idx;
  logic [NW-1:0]                 idx;
  logic [dgds_pkg::CHAN_W-1:0]   chan;
  logic signed [SW-1:0]          smp;
  logic                          eof;
  logic                          chan_ok;
  logic [TW-1:0]                 ld_index;
  logic                          ld_ok;
  logic [dgds_pkg::CHAN_W-1:0]   ld_src;
  logic                          ld_dest;
  logic [dgds_pkg::GAIN_W-1:0]   ld_gain;
  logic [DW-1:0]                 rem;
  logic                          cur_dest;
  logic [RW-1:0]                 cur_slot;
  logic signed [CW-1:0]          contrib;

  logic [NW-1:0]         n_ops;
  logic [NW-1:0]         idx_next;
  logic [RW:0]           slot_sum;
  logic [RW-1:0]         slot;
  logic signed [PW-1:0]  prod;
  logic signed [PW-1:0]  prod_rnd;
  logic [RCP_PW-1:0]     rcp_prod;
  logic [DW-1:0]         rcp_quot;
  logic [RCP_PW-1:0]     rcp_back;
  logic [DW-1:0]         rem_mod;
  logic signed [AW-1:0]  acc_old;
  logic signed [AW:0]    acc_sum;
  logic signed [AW-1:0]  acc_new;
  logic                  clip_l;
  logic                  clip_r;
  logic [SW-1:0]         sat_l;
  logic [SW-1:0]         sat_r;
  logic                  cfg_we;
  logic                  emit_go;

  logic                  tab_re;
  logic [TW-1:0]         tab_ra;
  logic                  tab_we;
  logic                  ring_re;
  logic [RW-1:0]         ring_ra;
  logic                  ring_we_l;
  logic                  ring_we_r;
  logic [RW-1:0]         ring_wa;
  logic signed [AW-1:0]  ring_wd;

  // Configuration port.
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[2] == dgds_pkg::REG_ACTIVE_OPS);

  always_ff @(posedge clk) begin
    if (rst) begin
      active_ops <= '0;
    end else if (cfg_we) begin
      active_ops <= pwdata[dgds_pkg::CFG_OPS_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == dgds_pkg::REG_ACTIVE_OPS) begin
      prdata = dgds_pkg::APB_DATA_W'(active_ops);
    end
  end

  // Datapath.
  assign n_ops    = (32'(active_ops) > 32'(MAX_OPS)) ? NW'(MAX_OPS) : NW'(active_ops);
  assign idx_next = idx + NW'(1);

  assign slot_sum = {1'b0, fp} + {1'b0, tab_q.delay};
  assign slot     = (slot_sum >= (RW + 1)'(RING_FRAMES)) ?
                    RW'(slot_sum - (RW + 1)'(RING_FRAMES)) : RW'(slot_sum);

  assign prod     = smp * $signed({1'b0, tab_q.gain});
  assign prod_rnd = prod + PW'(8192);

  // The loaded delay is reduced modulo RING_FRAMES by an exact reciprocal multiply.
  assign rcp_prod = RCP_PW'(rem) * RCP_PW'(RCP_M);
  assign rcp_quot = DW'(rcp_prod >> RCP_SH);
  assign rcp_back = RCP_PW'(rcp_quot) * RCP_PW'(RING_FRAMES);
  assign rem_mod  = DW'(RCP_PW'(rem) - rcp_back);

  assign acc_old = cur_dest ? ring_r_q : ring_l_q;
  assign acc_sum = (AW + 1)'(acc_old) + (AW + 1)'(contrib);
  assign acc_new = (acc_sum[AW] != acc_sum[AW-1]) ?
                   {acc_sum[AW], {(AW - 1){~acc_sum[AW]}}} : acc_sum[AW-1:0];

  assign clip_l = (ring_l_q[AW-1:SW-1] != {(AW - SW + 1){ring_l_q[AW-1]}});
  assign clip_r = (ring_r_q[AW-1:SW-1] != {(AW - SW + 1){ring_r_q[AW-1]}});
  assign sat_l  = clip_l ? {ring_l_q[AW-1], {(SW - 1){~ring_l_q[AW-1]}}} : ring_l_q[SW-1:0];
  assign sat_r  = clip_r ? {ring_r_q[AW-1], {(SW - 1){~ring_r_q[AW-1]}}} : ring_r_q[SW-1:0];

  assign item_stall = (state != S_IDLE);
  assign emit_go    = (state == S_EMIT) && (!result_valid || !result_stall);

  // Memory control.
  always_comb begin
    tab_re    = 1'b0;
    tab_ra    = '0;
    tab_we    = 1'b0;
    ring_re   = 1'b0;
    ring_ra   = slot;
    ring_we_l = 1'b0;
    ring_we_r = 1'b0;
    ring_wa   = cur_slot;
    ring_wd   = acc_new;
    case (state)
      S_CLEAR: begin
        ring_we_l = 1'b1;
        ring_we_r = 1'b1;
        ring_wa   = clr_idx;
        ring_wd   = '0;
      end
      S_LOAD: begin
        tab_we = ld_ok;
      end
      S_START: begin
        tab_re = chan_ok && (n_ops != '0);
      end
      S_EVAL: begin
        if (tab_q.src == chan) begin
          ring_re = 1'b1;
        end else if (idx_next != n_ops) begin
          tab_re = 1'b1;
          tab_ra = idx_next[TW-1:0];
        end
      end
      S_ADD: begin
        ring_we_l = ~cur_dest;
        ring_we_r = cur_dest;
        if (idx_next != n_ops) begin
          tab_re = 1'b1;
          tab_ra = idx_next[TW-1:0];
        end
      end
      S_FIN: begin
        ring_re = eof;
        ring_ra = fp;
      end
      S_EMIT: begin
        if (!result_valid || !result_stall) begin
          ring_we_l = 1'b1;
          ring_we_r = 1'b1;
          ring_wa   = fp;
          ring_wd   = '0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (tab_we) begin
      op_table[ld_index] <= '{src: ld_src, dest: ld_dest, delay: RW'(rem_mod), gain: ld_gain};
    end
    if (tab_re) begin
      tab_q <= op_table[tab_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (ring_we_l) begin
      ring_l[ring_wa] <= ring_wd;
    end
    if (ring_we_r) begin
      ring_r[ring_wa] <= ring_wd;
    end
    if (ring_re) begin
      ring_l_q <= ring_l[ring_ra];
      ring_r_q <= ring_r[ring_ra];
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      clr_idx      <= '0;
      fp           <= '0;
      idx          <= '0;
      result_valid <= 1'b0;
    end else begin
      if (emit_go) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + RW'(1);
          if (clr_idx == RW'(RING_FRAMES - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (item_valid) begin
            chan     <= channel;
            smp      <= sample;
            eof      <= end_of_frame;
            chan_ok  <= (32'(channel) < 32'(MAX_CHANNELS));
            ld_index <= TW'(entry_index);
            ld_ok    <= (32'(entry_index) < 32'(MAX_OPS));
            ld_src   <= entry_source;
            ld_dest  <= entry_dest;
            ld_gain  <= entry_gain;
            rem      <= entry_delay;
            state    <= (op == dgds_pkg::OP_LOAD) ? S_LOAD : S_START;
          end
        end
        S_LOAD: begin
          state <= S_IDLE;
        end
        S_START: begin
          idx   <= '0;
          state <= (chan_ok && (n_ops != '0)) ? S_EVAL : S_FIN;
        end
        S_EVAL: begin
          if (tab_q.src == chan) begin
            cur_dest <= tab_q.dest;
            cur_slot <= slot;
            contrib  <= prod_rnd[PW-1:dgds_pkg::ROUND_SH];
            state    <= S_ADD;
          end else begin
            idx <= idx_next;
            if (idx_next == n_ops) begin
              state <= S_FIN;
            end
          end
        end
        S_ADD: begin
          idx   <= idx_next;
          state <= (idx_next == n_ops) ? S_FIN : S_EVAL;
        end
        S_FIN: begin
          state <= eof ? S_EMIT : S_IDLE;
        end
        S_EMIT: begin
          if (emit_go) begin
            left_out     <= sat_l;
            right_out    <= sat_r;
            clipped      <= clip_l || clip_r;
            fp           <= (fp == RW'(RING_FRAMES - 1)) ? '0 : fp + RW'(1);
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- tb/sv/tb_delay_gain_downmix_to_stereo.sv -----
// Self-checking testbench for delay_gain_downmix_to_stereo: a directed table, then random frames.
// Random loads and noise run under several flow-control mixes, checked by an in-bench mix predictor.
// Depends on dgds_pkg and the delay_gain_downmix_to_stereo RTL.
module tb_delay_gain_downmix_to_stereo;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int OPS_N   = dgds_pkg::DEF_MAX_OPS;
  localparam int RING_N  = dgds_pkg::DEF_RING_FRAMES;
  localparam int CHANS_N = dgds_pkg::DEF_MAX_CHANNELS;
  localparam int SETTLE_CYCLES = 100;
  localparam longint ACC_HI = 64'sd2147483647;
  localparam longint ACC_LO = -64'sd2147483648;
  localparam longint OUT_HI = 64'sd8388607;
  localparam longint OUT_LO = -64'sd8388608;

  typedef enum int {FLOW_FREE, FLOW_SENDER, FLOW_RECEIVER, FLOW_BOTH} flow_t;

  typedef struct {
    bit                                 op;
    bit [dgds_pkg::CHAN_W-1:0]          channel;
    bit signed [dgds_pkg::SAMPLE_W-1:0] sample;
    bit                                 eof;
    bit [dgds_pkg::INDEX_W-1:0]         idx;
    bit [dgds_pkg::CHAN_W-1:0]          src;
    bit                                 dest;
    bit [dgds_pkg::DELAY_W-1:0]         delay;
    bit [dgds_pkg::GAIN_W-1:0]          gain;
  } request_t;

  typedef struct {
    bit signed [dgds_pkg::SAMPLE_W-1:0] left;
    bit signed [dgds_pkg::SAMPLE_W-1:0] right;
    bit                                 clipped;
  } stereo_t;

  typedef struct {
    bit [dgds_pkg::CHAN_W-1:0]  src;
    bit                         dest;
    bit [dgds_pkg::DELAY_W-1:0] delay;
    bit [dgds_pkg::GAIN_W-1:0]  gain;
  } tap_t;

  typedef struct {
    request_t                       req;
    bit                             cfg_en;
    bit [dgds_pkg::CFG_OPS_W-1:0]   cfg_val;
    bit                             typed;
    stereo_t                        want;
  } script_row_t;

  logic                                  clk;
  logic                                  rst = 1'b1;
  logic                                  item_valid = 1'b0;
  logic                                  item_stall;
  logic                                  op = 1'b0;
  logic [dgds_pkg::CHAN_W-1:0]           channel = '0;
  logic signed [dgds_pkg::SAMPLE_W-1:0]  sample = '0;
  logic                                  end_of_frame = 1'b0;
  logic [dgds_pkg::INDEX_W-1:0]          entry_index = '0;
  logic [dgds_pkg::CHAN_W-1:0]           entry_source = '0;
  logic                                  entry_dest = 1'b0;
  logic [dgds_pkg::DELAY_W-1:0]          entry_delay = '0;
  logic [dgds_pkg::GAIN_W-1:0]           entry_gain = '0;
  logic                                  result_valid;
  logic                                  result_stall = 1'b0;
  logic signed [dgds_pkg::SAMPLE_W-1:0]  left_out;
  logic signed [dgds_pkg::SAMPLE_W-1:0]  right_out;
  logic                                  clipped;
  logic                                  psel = 1'b0;
  logic                                  penable = 1'b0;
  logic                                  pwrite = 1'b0;
  logic [dgds_pkg::APB_ADDR_W-1:0]       paddr = '0;
  logic [dgds_pkg::APB_DATA_W-1:0]       pwdata = '0;
  logic [dgds_pkg::APB_DATA_W-1:0]       prdata;
  logic                                  pready;

  int left_acc [RING_N];
  int right_acc [RING_N];
  tap_t taps [OPS_N];
  int unsigned frame_ptr = 0;
  bit [dgds_pkg::CFG_OPS_W-1:0] cfg_active = '0;

  stereo_t pending_frames[$];
  script_row_t script[$];
  stereo_t seen_want;
  int gap_pct = 0;
  int stall_pct = 0;
  int requests_sent = 0;
  int loads_sent = 0;
  int frames_checked = 0;
  int frames_clipped = 0;
  int mismatches = 0;

  int phase_ops [9] = '{32, 63, 1, 17, 0, 32, 63, 0, 5};
  flow_t phase_flow [9] = '{FLOW_FREE, FLOW_SENDER, FLOW_RECEIVER, FLOW_BOTH, FLOW_FREE,
                            FLOW_BOTH, FLOW_RECEIVER, FLOW_SENDER, FLOW_FREE};

  delay_gain_downmix_to_stereo uut (
    .clk(clk), .rst(rst),
    .item_valid(item_valid), .item_stall(item_stall), .op(op), .channel(channel),
    .sample(sample), .end_of_frame(end_of_frame), .entry_index(entry_index),
    .entry_source(entry_source), .entry_dest(entry_dest), .entry_delay(entry_delay),
    .entry_gain(entry_gain),
    .result_valid(result_valid), .result_stall(result_stall), .left_out(left_out),
    .right_out(right_out), .clipped(clipped),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic bit signed [dgds_pkg::SAMPLE_W-1:0] fit_out(int acc, inout bit clip);
    longint v;
    v = acc;
    if (v > OUT_HI) begin
      v = OUT_HI;
      clip = 1'b1;
    end
    if (v < OUT_LO) begin
      v = OUT_LO;
      clip = 1'b1;
    end
    return v[dgds_pkg::SAMPLE_W-1:0];
  endfunction

  function automatic bit mix_step(request_t r, output stereo_t res);
    int unsigned n;
    int unsigned slot;
    longint contrib;
    longint total;
    res = '{default: 0};
    if (r.op == dgds_pkg::OP_LOAD) begin
      taps[r.idx] = '{r.src, r.dest, r.delay, r.gain};
      return 1'b0;
    end
    n = (cfg_active > OPS_N) ? OPS_N : cfg_active;
    if (r.channel < CHANS_N) begin
      for (int i = 0; i < n; i++) begin
        if (taps[i].src == r.channel) begin
          slot = (frame_ptr + taps[i].delay) % RING_N;
          contrib = (longint'(r.sample) * longint'(taps[i].gain) + 64'sd8192) >>>
                    dgds_pkg::ROUND_SH;
          total = longint'(taps[i].dest ? right_acc[slot] : left_acc[slot]) + contrib;
          if (total > ACC_HI) total = ACC_HI;
          if (total < ACC_LO) total = ACC_LO;
          if (taps[i].dest) right_acc[slot] = int'(total);
          else left_acc[slot] = int'(total);
        end
      end
    end
    if (!r.eof) return 1'b0;
    res.left = fit_out(left_acc[frame_ptr], res.clipped);
    res.right = fit_out(right_acc[frame_ptr], res.clipped);
    left_acc[frame_ptr] = 0;
    right_acc[frame_ptr] = 0;
    frame_ptr = (frame_ptr + 1) % RING_N;
    return 1'b1;
  endfunction

  function automatic bit [dgds_pkg::SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0: return 24'h7FFFFF;
      1: return 24'h800000;
      2: return 24'h000000;
      3: return 24'h000001;
      4: return 24'hFFFFFF;
      default: return dgds_pkg::SAMPLE_W'($urandom);
    endcase
  endfunction

  function automatic request_t random_request();
    request_t r;
    r.op = dgds_pkg::OP_SAMPLE;
    r.channel = dgds_pkg::CHAN_W'($urandom);
    r.sample = pick_sample();
    r.eof = 1'($urandom);
    r.idx = dgds_pkg::INDEX_W'($urandom);
    r.src = ($urandom_range(0, 9) == 0) ? dgds_pkg::CHAN_W'($urandom) :
                                          dgds_pkg::CHAN_W'($urandom_range(0, 8));
    r.dest = 1'($urandom);
    case ($urandom_range(0, 9))
      0, 1: r.delay = '0;
      2: r.delay = '1;
      3, 4, 5, 6: r.delay = dgds_pkg::DELAY_W'($urandom_range(1, 12));
      default: r.delay = dgds_pkg::DELAY_W'($urandom);
    endcase
    case ($urandom_range(0, 19))
      0, 1, 2, 3, 4: r.gain = '1;
      5, 6: r.gain = '0;
      7, 8: r.gain = 16'h4000;
      9: r.gain = 16'h2000;
      default: r.gain = dgds_pkg::GAIN_W'($urandom);
    endcase
    return r;
  endfunction

  function automatic void load_row(int idx, int src, bit dest, int delay, int gain, bit eof);
    script_row_t row;
    row = '{default: 0};
    row.req.op = dgds_pkg::OP_LOAD;
    row.req.idx = dgds_pkg::INDEX_W'(idx);
    row.req.src = dgds_pkg::CHAN_W'(src);
    row.req.dest = dest;
    row.req.delay = dgds_pkg::DELAY_W'(delay);
    row.req.gain = dgds_pkg::GAIN_W'(gain);
    row.req.eof = eof;
    script.push_back(row);
  endfunction

  function automatic void sample_row(int cfg, int ch, bit [dgds_pkg::SAMPLE_W-1:0] smp,
                                     bit eof, bit typed, bit [dgds_pkg::SAMPLE_W-1:0] l,
                                     bit [dgds_pkg::SAMPLE_W-1:0] r, bit clip);
    script_row_t row;
    row = '{default: 0};
    row.req.op = dgds_pkg::OP_SAMPLE;
    row.req.channel = dgds_pkg::CHAN_W'(ch);
    row.req.sample = smp;
    row.req.eof = eof;
    row.cfg_en = (cfg >= 0);
    row.cfg_val = dgds_pkg::CFG_OPS_W'(cfg);
    row.typed = typed;
    row.want = '{l, r, clip};
    script.push_back(row);
  endfunction

  function automatic void set_flow(flow_t f);
    gap_pct = (f == FLOW_SENDER) ? 75 : (f == FLOW_BOTH) ? 26 : 0;
    stall_pct = (f == FLOW_RECEIVER) ? 75 : (f == FLOW_BOTH) ? 26 : 0;
  endfunction

  always @(posedge clk) begin
    result_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (pending_frames.size() == 0) begin
        $error("unexpected stereo frame: left_out %0d right_out %0d clipped %0d",
               left_out, right_out, clipped);
        mismatches++;
      end else begin
        seen_want = pending_frames.pop_front();
        if (left_out !== seen_want.left) begin
          $error("left_out: expected %0d, got %0d", seen_want.left, left_out);
          mismatches++;
        end
        if (right_out !== seen_want.right) begin
          $error("right_out: expected %0d, got %0d", seen_want.right, right_out);
          mismatches++;
        end
        if (clipped !== seen_want.clipped) begin
          $error("clipped: expected %0d, got %0d", seen_want.clipped, clipped);
          mismatches++;
        end
        frames_checked++;
        if (seen_want.clipped) frames_clipped++;
      end
    end
  end

  // The caller sits just after a rising edge; the task returns at the edge that takes the request.
  task automatic push_request(request_t r, bit typed, stereo_t typed_mix);
    stereo_t predicted;
    while ($urandom_range(0, 99) < gap_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    op <= r.op;
    channel <= r.channel;
    sample <= r.sample;
    end_of_frame <= r.eof;
    entry_index <= r.idx;
    entry_source <= r.src;
    entry_dest <= r.dest;
    entry_delay <= r.delay;
    entry_gain <= r.gain;
    do @(posedge clk); while (item_stall);
    if (mix_step(r, predicted)) pending_frames.push_back(typed ? typed_mix : predicted);
    requests_sent++;
    if (r.op == dgds_pkg::OP_LOAD) loads_sent++;
  endtask

  task automatic settle();
    item_valid <= 1'b0;
    while (pending_frames.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_active_ops(bit [dgds_pkg::CFG_OPS_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= dgds_pkg::APB_ADDR_W'({dgds_pkg::REG_ACTIVE_OPS, 2'b00});
    pwdata <= dgds_pkg::APB_DATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    cfg_active = value;
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[dgds_pkg::CFG_OPS_W-1:0] !== value) begin
      $error("active_ops readback: expected %0d, got %0d", value,
             prdata[dgds_pkg::CFG_OPS_W-1:0]);
      mismatches++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_traffic(int count);
    request_t r;
    stereo_t no_mix;
    int sent;
    int len;
    int pick;
    no_mix = '{default: 0};
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(0, 99);
      r = random_request();
      if (pick < 8) begin
        r.op = dgds_pkg::OP_LOAD;
        push_request(r, 1'b0, no_mix);
        sent++;
      end else if (pick < 13) begin
        push_request(r, 1'b0, no_mix);
        sent++;
      end else begin
        len = (pick < 20) ? $urandom_range(20, 40) : $urandom_range(1, CHANS_N);
        for (int k = 0; k < len; k++) begin
          r = random_request();
          r.channel = (pick < 20) ? dgds_pkg::CHAN_W'($urandom_range(0, CHANS_N - 1)) :
                                    dgds_pkg::CHAN_W'(k);
          r.eof = (k == len - 1);
          push_request(r, 1'b0, no_mix);
          sent++;
        end
      end
    end
  endtask

  initial begin
    request_t r;
    stereo_t no_mix;
    no_mix = '{default: 0};
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    sample_row(-1, 0, 24'h7FFFFF, 1, 1, 24'h000000, 24'h000000, 0);
    load_row(0, 0, 0, 0, 16'hFFFF, 0);
    load_row(1, 0, 1, 0, 16'h4000, 1);
    load_row(2, 1, 0, 4095, 16'h4000, 0);
    load_row(3, 8, 1, 1, 16'h0001, 0);
    load_row(31, 15, 1, 4095, 16'h0000, 1);
    sample_row(4, 0, 24'h7FFFFF, 0, 0, 0, 0, 0);
    sample_row(-1, 8, 24'h800000, 0, 0, 0, 0, 0);
    sample_row(-1, 9, 24'h7FFFFF, 1, 1, 24'h7FFFFF, 24'h7FFFFF, 1);
    sample_row(-1, 15, 24'h7FFFFF, 1, 0, 0, 0, 0);
    sample_row(-1, 0, 24'h800000, 0, 0, 0, 0, 0);
    sample_row(-1, 1, 24'h123456, 1, 1, 24'h800000, 24'h800000, 1);
    load_row(0, 2, 0, 0, 16'h2000, 0);
    sample_row(-1, 2, 24'h000001, 0, 0, 0, 0, 0);
    sample_row(-1, 2, 24'hFFFFFF, 0, 0, 0, 0, 0);
    sample_row(-1, 2, 24'h000003, 1, 0, 0, 0, 0);
    sample_row(0, 0, 24'h7FFFFF, 1, 1, 24'h000000, 24'h000000, 0);

    foreach (script[i]) begin
      if (script[i].cfg_en) begin
        settle();
        write_active_ops(script[i].cfg_val);
      end
      push_request(script[i].req, script[i].typed, script[i].want);
    end

    for (int i = 0; i < OPS_N; i++) begin
      r = random_request();
      r.op = dgds_pkg::OP_LOAD;
      r.idx = dgds_pkg::INDEX_W'(i);
      push_request(r, 1'b0, no_mix);
    end

    foreach (phase_ops[p]) begin
      settle();
      write_active_ops((p == 7) ? dgds_pkg::CFG_OPS_W'($urandom_range(2, 31)) :
                                  dgds_pkg::CFG_OPS_W'(phase_ops[p]));
      set_flow(phase_flow[p]);
      run_traffic(50);
    end
    settle();

    $display("Sent %0d requests, %0d of them table loads; checked %0d stereo frames, %0d clipped.",
             requests_sent, loads_sent, frames_checked, frames_clipped);
    $display("Active entry counts from 0 to 63 were used under free, gapped and stalled flow.");
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/core/dgds_pkg.sv
rtl/core/delay_gain_downmix_to_stereo.sv
tb/sv/tb_delay_gain_downmix_to_stereo.sv
